/* sv/mrsp_pkg.sv */
// Shared types, constants and helpers for the MIDI running status parser.
`timescale 1ns / 1ps

package mrsp_pkg;

	localparam int MAX_FRAME = 63;
	localparam int FRAME_AW = $clog2(MAX_FRAME + 1);
	localparam int IN_W = 40;
	localparam int OUT_W = 72;

	localparam logic [7:0] BYTE_REALTIME = 8'hF8;
	localparam logic [7:0] BYTE_SYSEX_END = 8'hF7;
	localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
	localparam logic [7:0] BYTE_COMMON_LO = 8'hF1;
	localparam logic [7:0] BYTE_COMMON_HI = 8'hF6;
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON = 4'h9;
	localparam logic [3:0] NIB_POLY_AT = 4'hA;
	localparam logic [3:0] NIB_CONTROL = 4'hB;
	localparam logic [3:0] NIB_PROGRAM = 4'hC;
	localparam logic [3:0] NIB_CHAN_AT = 4'hD;
	localparam logic [3:0] NIB_PITCH = 4'hE;

	typedef enum logic [1:0] {
		OP_EVENT = 2'd0,
		OP_STORE = 2'd1,
		OP_DRAIN = 2'd2
	} op_t;

	// One request from the front to the back.
	typedef struct packed {
		op_t op;
		logic [31:0] stamp;
		logic [FRAME_AW-1:0] addr;
		logic [7:0] value;
		logic [7:0] tag;
		logic [7:0] status;
		logic [6:0] data0;
		logic [6:0] data1;
	} cmd_t;

	function automatic logic [1:0] data_needed(input logic [7:0] st);
		logic [1:0] n;
		case (st[7:4])
			NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CONTROL, NIB_PITCH: n = 2'd2;
			NIB_PROGRAM, NIB_CHAN_AT: n = 2'd1;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

/* sv/midi_running_status_parser.sv */
// Top level of the MIDI byte stream parser with running status and SysEx buffering.
//
//  Channel      Dir  Width  Contents
//  s_axis       in   40     byte_value, timestamp
//  m_axis       out  72     event and frame fields; tuser kind; tlast last
//  cfg          in   8      source_id write
//
// One byte is taken per cycle while the two-entry request queue has room.
// A channel event is loaded into the output register once its request reaches the back
// and the output is free; a SysEx frame of N stored bytes is replayed from the frame
// buffer, followed by a closing F7 byte, while further requests wait in the queue.
// Reset clears all parser state and the output valid flag; the frame buffer is
// not cleared, since only bytes of the current frame are ever read.
// A stalled output holds its request and backs the queue up to the input.
`timescale 1ns / 1ps

module midi_running_status_parser import mrsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [7:0] cfg_wdata,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// [7:0] byte_value, [39:8] timestamp
	input logic [IN_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [31:0] event_time, [39:32] source_tag, [43:40] msg_type, [47:44] channel,
	// [54:48] first_data, [61:55] second_data, [69:62] frame_byte, [71:70] zero
	output logic [OUT_W-1:0] m_axis_tdata,
	// [0] kind
	output logic m_axis_tuser,
	output logic m_axis_tlast
);

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	mrsp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(s_axis_tvalid),
		.in_data(s_axis_tdata),
		.in_ready(s_axis_tready),
		.push(push),
		.push_cmd(push_cmd),
		.queue_full(queue_full)
	);

	mrsp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(queue_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_cmd(head_cmd)
	);

	mrsp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(m_axis_tdata),
		.out_user(m_axis_tuser),
		.out_last(m_axis_tlast)
	);

endmodule

/* sv/mrsp_queue.sv */
// Two-entry request queue between the parser front and the output back.
`timescale 1ns / 1ps

module mrsp_queue import mrsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid)) else $error("queue popped while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");

endmodule

/* sv/mrsp_front.sv */
// Input side: running status parsing, frame tracking and request generation.
`timescale 1ns / 1ps

module mrsp_front import mrsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [7:0] cfg_wdata,
	input logic in_valid,
	input logic [IN_W-1:0] in_data,
	output logic in_ready,
	output logic push,
	output cmd_t push_cmd,
	input logic queue_full
);

	logic [7:0] source_id_q;
	logic in_frame_q, in_frame_d;
	logic [FRAME_AW-1:0] frame_len_q, frame_len_d;
	logic [7:0] status_q, status_d;
	logic [1:0] data_count_q, data_count_d;
	logic [1:0] expected_q, expected_d;
	logic [6:0] data0_q, data0_d;
	logic [6:0] data1_q, data1_d;

	logic take;
	logic [7:0] b;
	logic [31:0] t;
	logic [1:0] cnt_next;

	assign in_ready = !queue_full;
	assign take = in_valid && in_ready;
	assign b = in_data[7:0];
	assign t = in_data[39:8];

	always_comb begin
		in_frame_d = in_frame_q;
		frame_len_d = frame_len_q;
		status_d = status_q;
		data_count_d = data_count_q;
		expected_d = expected_q;
		data0_d = data0_q;
		data1_d = data1_q;
		cnt_next = data_count_q;
		push = 1'b0;
		push_cmd = '0;
		push_cmd.op = OP_EVENT;
		push_cmd.stamp = t;
		push_cmd.tag = source_id_q;
		if (take && (b < BYTE_REALTIME)) begin
			if (in_frame_q) begin
				if (b == BYTE_SYSEX_END) begin
					push = 1'b1;
					push_cmd.op = OP_DRAIN;
					push_cmd.addr = frame_len_q;
					frame_len_d = '0;
					in_frame_d = 1'b0;
				end else if (frame_len_q >= FRAME_AW'(MAX_FRAME)) begin
					frame_len_d = '0;
					in_frame_d = 1'b0;
				end else begin
					push = 1'b1;
					push_cmd.op = OP_STORE;
					push_cmd.addr = frame_len_q;
					push_cmd.value = b;
					frame_len_d = frame_len_q + 1'b1;
				end
			end else if (b == BYTE_SYSEX_START) begin
				in_frame_d = 1'b1;
				push = 1'b1;
				push_cmd.op = OP_STORE;
				push_cmd.addr = '0;
				push_cmd.value = b;
				frame_len_d = FRAME_AW'(1);
			end else if (b[7]) begin
				if ((b >= BYTE_COMMON_LO) && (b <= BYTE_COMMON_HI)) begin
					status_d = '0;
				end else begin
					status_d = b;
					data_count_d = '0;
					expected_d = data_needed(b);
					if (data_needed(b) == 2'd0) begin
						push = 1'b1;
						push_cmd.status = b;
						push_cmd.data0 = data0_q;
						push_cmd.data1 = '0;
					end
				end
			end else if (status_q != 8'h00) begin
				if (data_count_q < 2'd2) begin
					if (data_count_q == 2'd0) begin
						data0_d = b[6:0];
					end else begin
						data1_d = b[6:0];
					end
					cnt_next = data_count_q + 2'd1;
				end
				if (expected_q == 2'd0) begin
					expected_d = data_needed(status_q);
				end
				data_count_d = cnt_next;
				if (cnt_next >= expected_d) begin
					push = 1'b1;
					push_cmd.status = status_q;
					push_cmd.data0 = data0_d;
					push_cmd.data1 = (expected_d >= 2'd2) ? data1_d : 7'd0;
					data_count_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_id_q <= '0;
			in_frame_q <= 1'b0;
			frame_len_q <= '0;
			status_q <= '0;
			data_count_q <= '0;
			expected_q <= '0;
			data0_q <= '0;
			data1_q <= '0;
		end else begin
			if (cfg_wen) begin
				source_id_q <= cfg_wdata;
			end
			in_frame_q <= in_frame_d;
			frame_len_q <= frame_len_d;
			status_q <= status_d;
			data_count_q <= data_count_d;
			expected_q <= expected_d;
			data0_q <= data0_d;
			data1_q <= data1_d;
		end
	end

	a_frame_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (frame_len_q != '0)) else $error("open frame has no bytes");
	a_push_ready: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> take) else $error("request issued without an accepted byte");
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == 8'h00) || status_q[7]) else $error("running status lacks bit 7");

endmodule

/* sv/mrsp_back.sv */
// Output side: frame buffer, frame replay and the output register.
`timescale 1ns / 1ps

module mrsp_back import mrsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input cmd_t head_cmd,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [OUT_W-1:0] out_data,
	output logic out_user,
	output logic out_last
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic [7:0] mem [MAX_FRAME];
	logic [7:0] rdata_q;
	logic [FRAME_AW-1:0] ptr_q, ptr_d;
	logic [FRAME_AW-1:0] len_q, len_d;
	logic [31:0] time_q, time_d;
	logic mem_we;
	logic out_free;
	logic load;
	logic [OUT_W-1:0] ld_data;
	logic ld_user;
	logic ld_last;
	logic valid_q;
	logic [OUT_W-1:0] data_q;
	logic user_q;
	logic last_q;

	assign out_free = !valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		ptr_d = ptr_q;
		len_d = len_q;
		time_d = time_q;
		pop = 1'b0;
		mem_we = 1'b0;
		load = 1'b0;
		ld_data = '0;
		ld_user = 1'b0;
		ld_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					case (head_cmd.op)
						OP_EVENT: begin
							if (out_free) begin
								load = 1'b1;
								pop = 1'b1;
								ld_last = 1'b1;
								ld_data = {2'b00, 8'h00, head_cmd.data1, head_cmd.data0,
									head_cmd.status[3:0], head_cmd.status[7:4],
									head_cmd.tag, head_cmd.stamp};
							end
						end
						OP_STORE: begin
							pop = 1'b1;
							mem_we = 1'b1;
						end
						OP_DRAIN: begin
							pop = 1'b1;
							len_d = head_cmd.addr;
							time_d = head_cmd.stamp;
							ptr_d = '0;
							state_d = ST_DRAIN;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					load = 1'b1;
					ld_user = 1'b1;
					if (ptr_q < len_q) begin
						ld_data = {2'b00, rdata_q, 30'd0, time_q};
						ptr_d = ptr_q + 1'b1;
					end else begin
						ld_data = {2'b00, BYTE_SYSEX_END, 30'd0, time_q};
						ld_last = 1'b1;
						ptr_d = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
				ptr_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head_cmd.addr] <= head_cmd.value;
		end
		if (ptr_d < FRAME_AW'(MAX_FRAME)) begin
			rdata_q <= mem[ptr_d];
		end
	end

	always_ff @(posedge clk) begin
		len_q <= len_d;
		time_q <= time_d;
		if (load) begin
			data_q <= ld_data;
			user_q <= ld_user;
			last_q <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q <= ptr_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;
	assign out_user = user_q;
	assign out_last = last_q;

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (ptr_q <= len_q)) else $error("replay pointer past frame");
	a_no_pop_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !pop) else $error("request taken during replay");
	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !user_q) |-> last_q) else $error("event result not marked last");
	a_idle_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (ptr_q == '0)) else $error("pointer not cleared in idle");

endmodule
